@@ hdl/cubic_bezier_segment_subdivider_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cubic Bezier segment subdivider
// Concurrent checks on clk_i; the reset variant is gated off while rst_ni is low.
// ---------------------------------------------------------------------------
`ifndef CUBIC_BEZIER_SEGMENT_SUBDIVIDER_DEFINES_SVH
`define CUBIC_BEZIER_SEGMENT_SUBDIVIDER_DEFINES_SVH

`ifndef SYNTH
// check that holds outside reset
`define CBS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// check that holds at every edge, reset included
`define CBS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define CBS_ASSERT(lbl, prop, msg)
`define CBS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/cbs_pkg.sv @@
// ---------------------------------------------------------------------------
// cbs_pkg
// Shared widths, constants, command/status structs and saturation helper.
// ---------------------------------------------------------------------------
package cbs_pkg;

  // coordinate format: signed, 23 fraction bits
  localparam int COORD_W   = 32;
  localparam int CFG_W     = 6;
  localparam int CFG_RESET = 16;

  // curve parameter t: unsigned, 24 fraction bits, range 0..1.0
  localparam int T_FRAC = 24;
  localparam int T_W    = T_FRAC + 1;
  localparam logic [T_W-1:0] T_ONE = T_W'(1) << T_FRAC;

  // restoring division of 1.0 by the segment count, one quotient bit a step
  localparam int DIV_STEPS = T_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Bernstein weight (up to 3.0), weighted product and sum widths
  localparam int W_W    = T_W + 1;
  localparam int PROD_W = W_W + 1 + COORD_W;
  localparam int SUM_W  = PROD_W + 2;
  localparam int RND_W  = SUM_W - T_FRAC;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic        [T_W-1:0]     tval_t;
  typedef logic        [W_W-1:0]     weight_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // take a new request, reset the step state
    logic emit_start;  // load start anchor into the output register
    logic emit_end;    // load end anchor (straight segment)
    logic emit_pt;     // load computed curve point
    logic div_step;    // one bit of the reciprocal division
    logic div_first;   // first division step feeds the dividend's one bit
    logic t_step;      // advance t by 1/N
    logic mul_a;       // uu, tt
    logic mul_b;       // Bernstein weights
    logic mul_c;       // weighted coordinates
    logic add1;        // pairwise sums plus rounding constant
    logic add2;        // final sum, floor shift, saturate
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic curved;      // at least one control present
    logic fin;         // current point is the last of the curve
    logic out_free;    // output register can take a value this cycle
  } status_t;

  // clamp the shifted sum to the coordinate range
  function automatic coord_t sat_coord(input logic signed [RND_W-1:0] v);
    logic hi_ones;
    logic hi_zeros;
    hi_ones  = &v[RND_W-1:COORD_W-1];
    hi_zeros = ~|v[RND_W-1:COORD_W-1];
    if (hi_ones || hi_zeros) begin
      sat_coord = v[COORD_W-1:0];
    end else if (v[RND_W-1]) begin
      sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
    end
  endfunction

endpackage

@@ hdl/cbs_ctrl.sv @@
// ---------------------------------------------------------------------------
// cbs_ctrl
// Sequencer: request intake, reciprocal division, per-point compute steps
// and output loading.
// ---------------------------------------------------------------------------
module cbs_ctrl
  import cbs_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_END   = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_TSTEP = 4'd4;
  localparam logic [3:0] S_MULA  = 4'd5;
  localparam logic [3:0] S_MULB  = 4'd6;
  localparam logic [3:0] S_MULC  = 4'd7;
  localparam logic [3:0] S_ADD1  = 4'd8;
  localparam logic [3:0] S_ADD2  = 4'd9;
  localparam logic [3:0] S_EMIT  = 4'd10;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);

  logic [3:0]           state_q, state_d;
  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_START;
        end
      end
      S_START: begin
        if (status_i.out_free) begin
          cmd_o.emit_start = 1'b1;
          cnt_d            = '0;
          state_d          = status_i.curved ? S_DIV : S_END;
        end
      end
      S_END: begin
        if (status_i.out_free) begin
          cmd_o.emit_end = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step  = 1'b1;
        cmd_o.div_first = (cnt_q == '0);
        cnt_d           = cnt_q + 1'b1;
        if (cnt_q == DIV_LAST) begin
          state_d = S_TSTEP;
        end
      end
      S_TSTEP: begin
        cmd_o.t_step = 1'b1;
        state_d      = S_MULA;
      end
      S_MULA: begin
        cmd_o.mul_a = 1'b1;
        state_d     = S_MULB;
      end
      S_MULB: begin
        cmd_o.mul_b = 1'b1;
        state_d     = S_MULC;
      end
      S_MULC: begin
        cmd_o.mul_c = 1'b1;
        state_d     = S_ADD1;
      end
      S_ADD1: begin
        cmd_o.add1 = 1'b1;
        state_d    = S_ADD2;
      end
      S_ADD2: begin
        cmd_o.add2 = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit_pt = 1'b1;
          state_d       = status_i.fin ? S_IDLE : S_TSTEP;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ hdl/cbs_datapath.sv @@
// ---------------------------------------------------------------------------
// cbs_datapath
// Segment registers, reciprocal divider, t stepping, Bernstein weights,
// weighted sums with rounding and saturation, and the output register.
// ---------------------------------------------------------------------------
module cbs_datapath
  import cbs_pkg::*;
#(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output status_t          status_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  coord_t           start_x_i,
  input  coord_t           start_y_i,
  input  coord_t           exit_ctl_x_i,
  input  coord_t           exit_ctl_y_i,
  input  logic             has_exit_ctl_i,
  input  coord_t           end_x_i,
  input  coord_t           end_y_i,
  input  coord_t           entry_ctl_x_i,
  input  coord_t           entry_ctl_y_i,
  input  logic             has_entry_ctl_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output coord_t           point_x_o,
  output coord_t           point_y_o,
  output logic             curve_start_o,
  output logic             curve_end_o,
  output logic             last_o
);

  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam sum_t ROUND = sum_t'(1) <<< (T_FRAC - 1);

  // configuration
  logic [CFG_W-1:0] num_seg_q;

  // segment registers
  coord_t sx_q, sy_q, ax_q, ay_q, bx_q, by_q, ex_q, ey_q;
  logic   curved_q;
  logic [CNT_W-1:0] n_q, n_d;

  // divider and t stepping
  logic [CNT_W-1:0] rem_q, r_q, i_q;
  tval_t            quot_q, t_q, u_q;

  // compute pipeline
  tval_t   uu_q, tt_q;
  weight_t w0_q, w1_q, w2_q, w3_q;
  prod_t   px0_q, px1_q, px2_q, px3_q, py0_q, py1_q, py2_q, py3_q;
  sum_t    sxa_q, sxb_q, sya_q, syb_q;
  coord_t  rx_q, ry_q;

  // output register
  logic   out_valid_q;
  coord_t ox_q, oy_q;
  logic   ocs_q, oce_q, olast_q;

  logic out_free;
  logic fin;

  assign out_free = !out_valid_q || out_ready_i;
  assign fin      = (i_q == n_q);

  assign status_o.curved   = curved_q;
  assign status_o.fin      = fin;
  assign status_o.out_free = out_free;

  // configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_seg_q <= CFG_W'(CFG_RESET);
    end else if (cfg_we_i) begin
      num_seg_q <= cfg_wdata_i;
    end
  end

  // effective segment count: zero reads as one, clamp to the limit
  always_comb begin
    if (num_seg_q == '0) begin
      n_d = CNT_W'(1);
    end else if (int'(num_seg_q) > MAX_SEGMENTS) begin
      n_d = CNT_W'(MAX_SEGMENTS);
    end else begin
      n_d = CNT_W'(num_seg_q);
    end
  end

  // request capture, missing controls fall back to their anchors
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      sx_q     <= start_x_i;
      sy_q     <= start_y_i;
      ex_q     <= end_x_i;
      ey_q     <= end_y_i;
      ax_q     <= has_exit_ctl_i ? exit_ctl_x_i : start_x_i;
      ay_q     <= has_exit_ctl_i ? exit_ctl_y_i : start_y_i;
      bx_q     <= has_entry_ctl_i ? entry_ctl_x_i : end_x_i;
      by_q     <= has_entry_ctl_i ? entry_ctl_y_i : end_y_i;
      curved_q <= has_exit_ctl_i || has_entry_ctl_i;
      n_q      <= n_d;
    end
  end

  // restoring divider for 1.0 / N; quotient and remainder feed t stepping
  logic [CNT_W:0] rem_sh;
  logic           rem_ge;
  assign rem_sh = {rem_q, cmd_i.div_first};
  assign rem_ge = (rem_sh >= {1'b0, n_q});

  // t stepping: t += q0 with the remainder carried, u = 1.0 - t
  logic [CNT_W:0] r_sum;
  logic           r_ge;
  tval_t          t_next;
  assign r_sum  = {1'b0, r_q} + {1'b0, rem_q};
  assign r_ge   = (r_sum >= {1'b0, n_q});
  assign t_next = t_q + quot_q + T_W'(r_ge);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      rem_q  <= '0;
      quot_q <= '0;
      r_q    <= '0;
      i_q    <= '0;
      t_q    <= '0;
      u_q    <= T_ONE;
    end else if (cmd_i.div_step) begin
      rem_q  <= rem_ge ? CNT_W'(rem_sh - {1'b0, n_q}) : CNT_W'(rem_sh);
      quot_q <= {quot_q[T_W-2:0], rem_ge};
    end else if (cmd_i.t_step) begin
      r_q <= r_ge ? CNT_W'(r_sum - {1'b0, n_q}) : CNT_W'(r_sum);
      t_q <= t_next;
      u_q <= T_ONE - t_next;
      i_q <= i_q + 1'b1;
    end
  end

  // squares
  logic [2*T_W-1:0] m_uu, m_tt;
  assign m_uu = u_q * u_q;
  assign m_tt = t_q * t_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_a) begin
      uu_q <= m_uu[T_FRAC+T_W-1:T_FRAC];
      tt_q <= m_tt[T_FRAC+T_W-1:T_FRAC];
    end
  end

  // Bernstein weights, truncated products, inner two scaled by three
  logic [2*T_W-1:0] m_w0, m_w1, m_w2, m_w3;
  weight_t          h1, h2;
  assign m_w0 = uu_q * u_q;
  assign m_w1 = uu_q * t_q;
  assign m_w2 = u_q * tt_q;
  assign m_w3 = tt_q * t_q;
  assign h1   = W_W'(m_w1[T_FRAC+T_W-1:T_FRAC]);
  assign h2   = W_W'(m_w2[T_FRAC+T_W-1:T_FRAC]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_b) begin
      w0_q <= W_W'(m_w0[T_FRAC+T_W-1:T_FRAC]);
      w1_q <= (h1 << 1) + h1;
      w2_q <= (h2 << 1) + h2;
      w3_q <= W_W'(m_w3[T_FRAC+T_W-1:T_FRAC]);
    end
  end

  // weighted coordinates
  logic signed [W_W:0] ws0, ws1, ws2, ws3;
  assign ws0 = {1'b0, w0_q};
  assign ws1 = {1'b0, w1_q};
  assign ws2 = {1'b0, w2_q};
  assign ws3 = {1'b0, w3_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_c) begin
      px0_q <= ws0 * sx_q;
      px1_q <= ws1 * ax_q;
      px2_q <= ws2 * bx_q;
      px3_q <= ws3 * ex_q;
      py0_q <= ws0 * sy_q;
      py1_q <= ws1 * ay_q;
      py2_q <= ws2 * by_q;
      py3_q <= ws3 * ey_q;
    end
  end

  // pairwise sums, rounding half folded into the first pair
  always_ff @(posedge clk_i) begin
    if (cmd_i.add1) begin
      sxa_q <= sum_t'(px0_q) + sum_t'(px1_q) + ROUND;
      sxb_q <= sum_t'(px2_q) + sum_t'(px3_q);
      sya_q <= sum_t'(py0_q) + sum_t'(py1_q) + ROUND;
      syb_q <= sum_t'(py2_q) + sum_t'(py3_q);
    end
  end

  // final sum, floor by 2^24, saturate
  sum_t sum_x, sum_y;
  assign sum_x = sxa_q + sxb_q;
  assign sum_y = sya_q + syb_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.add2) begin
      rx_q <= sat_coord(sum_x[SUM_W-1:T_FRAC]);
      ry_q <= sat_coord(sum_y[SUM_W-1:T_FRAC]);
    end
  end

  // output register: valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_start || cmd_i.emit_end || cmd_i.emit_pt) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register: payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_start) begin
      ox_q    <= sx_q;
      oy_q    <= sy_q;
      ocs_q   <= curved_q;
      oce_q   <= 1'b0;
      olast_q <= 1'b0;
    end else if (cmd_i.emit_end) begin
      ox_q    <= ex_q;
      oy_q    <= ey_q;
      ocs_q   <= 1'b0;
      oce_q   <= 1'b0;
      olast_q <= 1'b1;
    end else if (cmd_i.emit_pt) begin
      ox_q    <= rx_q;
      oy_q    <= ry_q;
      ocs_q   <= 1'b0;
      oce_q   <= fin;
      olast_q <= fin;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign point_x_o     = ox_q;
  assign point_y_o     = oy_q;
  assign curve_start_o = ocs_q;
  assign curve_end_o   = oce_q;
  assign last_o        = olast_q;

endmodule

@@ hdl/cubic_bezier_segment_subdivider.sv @@
// ---------------------------------------------------------------------------
// cubic_bezier_segment_subdivider
// Turns one path segment into a list of vertices on a cubic Bezier curve.
// ---------------------------------------------------------------------------
// One request is taken at a time, and only while the sequencer is idle. A
// straight segment (no controls) gives its two anchors. A curved segment
// gives the start anchor, then N points at t = i/N: the sequencer takes the
// request and loads the start anchor, runs the bit-serial 1/N division that
// seeds the t stepper, then steps each point through the compute chain (t
// step, squares, weights, weighted products, two adder levels, output load).
// Each anchor and point load waits while the output is stalled. The
// output register lets a new request enter while the final vertex still waits.
// ---------------------------------------------------------------------------
`include "cubic_bezier_segment_subdivider_defines.svh"

module cubic_bezier_segment_subdivider
  import cbs_pkg::*;
#(
  parameter int MAX_SEGMENTS = 63
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  coord_t           start_x_i,
  input  coord_t           start_y_i,
  input  coord_t           exit_ctl_x_i,
  input  coord_t           exit_ctl_y_i,
  input  logic             has_exit_ctl_i,
  input  coord_t           end_x_i,
  input  coord_t           end_y_i,
  input  coord_t           entry_ctl_x_i,
  input  coord_t           entry_ctl_y_i,
  input  logic             has_entry_ctl_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output coord_t           point_x_o,
  output coord_t           point_y_o,
  output logic             curve_start_o,
  output logic             curve_end_o,
  output logic             last_o
);

  cmd_t    cmd;
  status_t status;

  // sequencer
  cbs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  cbs_datapath #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .exit_ctl_x_i    (exit_ctl_x_i),
    .exit_ctl_y_i    (exit_ctl_y_i),
    .has_exit_ctl_i  (has_exit_ctl_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .entry_ctl_x_i   (entry_ctl_x_i),
    .entry_ctl_y_i   (entry_ctl_y_i),
    .has_entry_ctl_i (has_entry_ctl_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .point_x_o       (point_x_o),
    .point_y_o       (point_y_o),
    .curve_start_o   (curve_start_o),
    .curve_end_o     (curve_end_o),
    .last_o          (last_o)
  );

  // checks
  `CBS_ASSERT(a_busy_after_req, (in_valid_i && in_ready_o) |=> !in_ready_o, "request taken while busy")
  `CBS_ASSERT(a_no_step_past_end, cmd.t_step |-> !status.fin, "t stepped past the final point")
  `CBS_ASSERT(a_end_is_last, (out_valid_o && curve_end_o) |-> last_o, "curve end without last flag")
  `CBS_ASSERT(a_start_not_last, (out_valid_o && curve_start_o) |-> !last_o, "curve start flagged last")
  `CBS_ASSERT_ALWAYS(a_load_only_free, (cmd.emit_start || cmd.emit_end || cmd.emit_pt) |-> status.out_free, "output overwritten")

endmodule
